// ===== rtl/pcfk_pkg.sv =====
// Package for the planar chain forward kinematics core: widths, tables,
// state types and saturating helpers. Depends on nothing.
`timescale 1ns / 1ps

package pcfk_pkg;

  localparam int MAX_JOINTS   = 64;
  localparam int ROTATE_STEPS = 16;

  // Count caps at the smaller of MAX_JOINTS-1 and 63
  localparam int COUNT_CAP = ((MAX_JOINTS - 1) < 63) ? (MAX_JOINTS - 1) : 63;
  localparam int STEP_W    = (ROTATE_STEPS > 1) ? $clog2(ROTATE_STEPS) : 1;

  // Rotator vector width: Q16.18 plus headroom for CORDIC growth
  localparam int VW = 40;

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 72;

  // Configuration register indexes
  localparam logic CFG_ROOT_X = 1'b0;
  localparam logic CFG_ROOT_Y = 1'b1;

  // 1/K in Q0.30
  localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81,
    32'd40,        32'd20,        32'd10,        32'd5,
    32'd2,         32'd1,         32'd0,         32'd0
  };

  typedef enum logic [2:0] {
    ROT_IDLE,
    ROT_MULX,
    ROT_MULY,
    ROT_STEP,
    ROT_DONE
  } rot_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFS_GO,
    S_OFS_WAIT,
    S_JOINT_OUT,
    S_BONE_GO,
    S_BONE_WAIT,
    S_TIP_OUT
  } fk_state_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [15:0] angle;
  } rot_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rot_sts_t;

  // Saturate a rotator-width value to signed 32 bits
  function automatic logic signed [31:0] sat_vw(input logic signed [VW-1:0] v);
    logic [VW-32:0] top;
    top = v[VW-1:31];
    if (top == '0 || top == '1) begin
      return v[31:0];
    end
    return v[VW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // Saturating signed 32-bit add
  function automatic logic signed [31:0] add_sat32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

endpackage

// ===== rtl/pcfk_rotator.sv =====
// Shared rotation unit: one prescale multiplier and an iterative CORDIC.
// Depends on pcfk_pkg.
`timescale 1ns / 1ps

module pcfk_rotator (
  input  logic               clk,
  input  logic               rst_n,
  input  pcfk_pkg::rot_req_t req,
  output pcfk_pkg::rot_sts_t sts,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y
);
  import pcfk_pkg::*;

  rot_state_t state_r, state_nxt;

  logic signed [31:0]   xin_r, yin_r;
  logic signed [VW-1:0] vx_r, vy_r;
  logic        [31:0]   z_r;
  logic                 neg_r;
  logic [STEP_W-1:0]    step_r;

  logic signed [31:0]   mul_a;
  logic signed [61:0]   prod;
  logic signed [33:0]   scaled34;
  logic signed [VW-1:0] scaled;
  logic        [4:0]    shamt;
  logic signed [VW-1:0] dx, dy;
  logic        [31:0]   z_start, z_biased;
  logic signed [VW-1:0] rnd_x, rnd_y;

  // Shared multiplier: x on the first pass, y on the second
  assign mul_a    = (state_r == ROT_MULY) ? yin_r : xin_r;
  assign prod     = 62'(mul_a) * 62'(INV_GAIN_Q30);
  assign scaled34 = prod[61:28];
  assign scaled   = neg_r ? -VW'(scaled34) : VW'(scaled34);

  assign shamt = 5'(step_r);
  assign dx    = vy_r >>> shamt;
  assign dy    = vx_r >>> shamt;

  assign z_start  = {req.angle, 16'h0000};
  assign z_biased = z_start + 32'h4000_0000;

  assign rnd_x = (vx_r + VW'(2)) >>> 2;
  assign rnd_y = (vy_r + VW'(2)) >>> 2;
  assign rot_x = sat_vw(rnd_x);
  assign rot_y = sat_vw(rnd_y);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ROT_IDLE: if (req.start) state_nxt = ROT_MULX;
      ROT_MULX: state_nxt = ROT_MULY;
      ROT_MULY: state_nxt = ROT_STEP;
      ROT_STEP: if (step_r == STEP_W'(ROTATE_STEPS - 1)) state_nxt = ROT_DONE;
      ROT_DONE: state_nxt = ROT_IDLE;
      default:  state_nxt = ROT_IDLE;
    endcase
  end

  always_comb begin
    sts.busy = (state_r != ROT_IDLE);
    sts.done = (state_r == ROT_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ROT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ROT_IDLE: begin
        if (req.start) begin
          xin_r  <= req.x;
          yin_r  <= req.y;
          step_r <= '0;
          // Angles in the back half-plane pre-rotate by half a turn
          neg_r  <= z_biased[31];
          z_r    <= z_biased[31] ? (z_start + 32'h8000_0000) : z_start;
        end
      end
      ROT_MULX: vx_r <= scaled;
      ROT_MULY: vy_r <= scaled;
      ROT_STEP: begin
        if (z_r[31]) begin
          vx_r <= vx_r + dx;
          vy_r <= vy_r - dy;
          z_r  <= z_r + ATAN_TAB[shamt];
        end else begin
          vx_r <= vx_r - dx;
          vy_r <= vy_r + dy;
          z_r  <= z_r - ATAN_TAB[shamt];
        end
        step_r <= step_r + 1'b1;
      end
      ROT_DONE: ;
      default: ;
    endcase
  end

endmodule

// ===== rtl/planar_chain_forward_kinematics_core.sv =====
// Top level of the planar chain forward kinematics core: joint sequencer,
// running pose, configuration and output register. Depends on pcfk_pkg
// and pcfk_rotator.
`timescale 1ns / 1ps

// Usage
//   in_*  : one joint per word, in chain order. in_tuser is first_joint
//           (restart from root_x/root_y with zero angle), in_tlast marks the
//           chain end. Limits are applied to the joint angle before it is
//           added to the running angle, lower limit first.
//   out_* : a joint word for every input word, plus a tip word (out_tlast
//           high) after a word marked last.
//   cfg_* : root_x at index 0, root_y at index 1; write only while idle.
// Sequence
//   Each joint takes two rotations through the one shared rotator: two
//   multiplier passes, ROTATE_STEPS CORDIC steps and a done state.
//   A new word is taken only once the sequencer is back in idle.
//   out_tvalid is registered from the joint state after the offset rotation
//   and from the tip state after the bone rotation; a stall can hold either.
// Reset and stall
//   Reset clears the root, the running pose and the joint count and drops
//   any pending output word. A stalled receiver holds the output register;
//   the sequencer then waits before writing the next result into it, while
//   a new input word is still taken whenever the sequencer is idle.

module planar_chain_forward_kinematics_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, lowest bit up: offset_x[31:0], offset_y[63:32],
  // bone_length[95:64], joint_angle[111:96], has_min[112],
  // lo_limit[128:113], has_max[129], hi_limit[145:130], zero fill
  input  logic [pcfk_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,  // first_joint
  input  logic                             in_tlast,  // chain_end
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata, lowest bit up: pos_x[31:0], pos_y[63:32],
  // joint_number[69:64], zero fill
  output logic [pcfk_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast, // is_tip
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [31:0]                      cfg_wdata
);
  import pcfk_pkg::*;

  fk_state_t state_r, state_nxt;

  logic signed [31:0] root_x_r, root_y_r;
  logic signed [31:0] run_x_r, run_y_r;
  logic        [15:0] run_angle_r;
  logic        [5:0]  joint_count_r;

  logic signed [31:0] ofs_x_r, ofs_y_r, bone_r;
  logic signed [15:0] ang_r;
  logic               last_r;

  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tlast_r, out_tvalid_r;

  rot_req_t rot_req;
  rot_sts_t rot_sts;
  logic signed [31:0] rot_x, rot_y;

  // Input unpacking and limit clamp
  logic signed [15:0] in_angle, in_min, in_max, ang_lo, ang_clamped;
  logic               in_has_min, in_has_max;
  logic               in_accept, slot_free, out_load, count_adv;
  logic signed [31:0] sum_x, sum_y;

  assign in_angle   = in_tdata[111:96];
  assign in_has_min = in_tdata[112];
  assign in_min     = in_tdata[128:113];
  assign in_has_max = in_tdata[129];
  assign in_max     = in_tdata[145:130];

  assign ang_lo      = (in_has_min && (in_angle < in_min)) ? in_min : in_angle;
  assign ang_clamped = (in_has_max && (ang_lo > in_max)) ? in_max : ang_lo;

  assign in_accept = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;

  assign sum_x = add_sat32(run_x_r, rot_x);
  assign sum_y = add_sat32(run_y_r, rot_y);

  pcfk_rotator u_rotator (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rot_req),
    .sts   (rot_sts),
    .rot_x (rot_x),
    .rot_y (rot_y)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_tvalid) state_nxt = S_OFS_GO;
      S_OFS_GO:    state_nxt = S_OFS_WAIT;
      S_OFS_WAIT:  if (rot_sts.done) state_nxt = S_JOINT_OUT;
      S_JOINT_OUT: if (slot_free) state_nxt = S_BONE_GO;
      S_BONE_GO:   state_nxt = S_BONE_WAIT;
      S_BONE_WAIT: if (rot_sts.done) state_nxt = S_TIP_OUT;
      S_TIP_OUT:   if (!last_r || slot_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready     = 1'b0;
    rot_req.start = 1'b0;
    rot_req.x     = ofs_x_r;
    rot_req.y     = ofs_y_r;
    rot_req.angle = run_angle_r;
    out_load      = 1'b0;
    count_adv     = 1'b0;
    unique case (state_r)
      S_IDLE:      in_tready = 1'b1;
      S_OFS_GO:    rot_req.start = 1'b1;
      S_OFS_WAIT:  ;
      S_JOINT_OUT: out_load = slot_free;
      S_BONE_GO: begin
        rot_req.start = 1'b1;
        rot_req.x     = bone_r;
        rot_req.y     = '0;
      end
      S_BONE_WAIT: begin
        rot_req.x = bone_r;
        rot_req.y = '0;
      end
      S_TIP_OUT: begin
        out_load  = last_r && slot_free;
        count_adv = !last_r || slot_free;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      root_x_r      <= '0;
      root_y_r      <= '0;
      run_x_r       <= '0;
      run_y_r       <= '0;
      run_angle_r   <= '0;
      joint_count_r <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROOT_X: root_x_r <= cfg_wdata;
          CFG_ROOT_Y: root_y_r <= cfg_wdata;
          default: ;
        endcase
      end

      // Restart the chain at the root
      if (in_accept && in_tuser) begin
        run_x_r       <= root_x_r;
        run_y_r       <= root_y_r;
        run_angle_r   <= '0;
        joint_count_r <= '0;
      end

      // Joint position, then turn by the clamped joint angle
      if (state_r == S_JOINT_OUT && slot_free) begin
        run_x_r     <= sum_x;
        run_y_r     <= sum_y;
        run_angle_r <= run_angle_r + ang_r;
      end

      // Advance along the bone; the count moves once per joint
      if (state_r == S_TIP_OUT && count_adv) begin
        run_x_r <= sum_x;
        run_y_r <= sum_y;
        if (joint_count_r < 6'(COUNT_CAP)) begin
          joint_count_r <= joint_count_r + 1'b1;
        end
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ofs_x_r <= in_tdata[31:0];
      ofs_y_r <= in_tdata[63:32];
      bone_r  <= in_tdata[95:64];
      ang_r   <= ang_clamped;
      last_r  <= in_tlast;
    end
    if (out_load) begin
      out_tdata_r <= {2'b00, joint_count_r, sum_y, sum_x};
      out_tlast_r <= (state_r == S_TIP_OUT);
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tvalid = out_tvalid_r;

  // A new result never lands on a word the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_tvalid_r || out_tready))
    else $error("output word overwritten");

  // The sequencer only takes a word while the rotator is free
  a_idle_rot_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !rot_sts.busy)
    else $error("input taken while rotator busy");

  // Rotator completion is only seen while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rot_sts.done |-> (state_r == S_OFS_WAIT || state_r == S_BONE_WAIT))
    else $error("rotator done outside a wait state");

  // A start always reaches an idle rotator
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rot_req.start |-> !rot_sts.busy)
    else $error("rotator started while busy");

endmodule
